// ----- rtl/lj_pkg.sv -----
package lj_pkg;

  // Division steps for q = floor(2^104 / S), one quotient bit per stage
  localparam int unsigned DIV_STEPS = 64;
  // Stages: square, sum, divide, 2 normalize, 9 multiply, 4 subtract, 5 output
  localparam int unsigned N_STAGES  = DIV_STEPS + 22;

  localparam int unsigned EXP_W = 12;
  typedef logic signed [EXP_W-1:0] exp_t;

  localparam logic [63:0] NEAR_LIMIT = 64'h0000_0100_0000_0000;
  localparam logic [47:0] POS_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MAX    = 48'h8000_0000_0000;
  localparam exp_t        Q_EXP0     = -exp_t'(56);
  localparam logic [4:0]  LJ_FORCE_K = 5'd24;
  localparam logic [2:0]  LJ_POT_K   = 3'd4;

  // Per-item data that rides along the whole pipeline
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             near;
  } side_t;

  // Unsigned value m * 2^e, m normalized (bit 63 set) or zero
  typedef struct packed {
    logic [63:0] m;
    exp_t        e;
  } xval_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] rem;
    logic [63:0] qr;
    side_t       side;
  } div_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
  } pp_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p3;
    logic [64:0] mid;
  } pm_t;

  typedef struct packed {
    logic [63:0] big_m;
    logic [63:0] small_m;
    exp_t        big_e;
    exp_t        d;
    logic        neg;
    logic        eq;
  } sel_t;

  typedef struct packed {
    logic [99:0] p;
    exp_t        k;
    logic        neg;
  } fld_t;

  typedef struct packed {
    logic [99:0] t;
    logic        ksat;
    logic        neg;
  } shf_t;

  // One restoring division step
  function automatic div_t div_step(input div_t x);
    div_t        r;
    logic [64:0] t;
    logic        ge;
    r  = x;
    t  = {x.rem, 1'b0};
    ge = (t >= {1'b0, x.s});
    r.rem = ge ? 64'(t - {1'b0, x.s}) : t[63:0];
    r.qr  = {x.qr[62:0], ge};
    return r;
  endfunction

  // Conditional left shift by sh when the top sh bits are clear
  function automatic xval_t norm_step(input xval_t x, input int unsigned sh);
    xval_t r;
    r = x;
    if ((x.m >> (64 - sh)) == 64'd0) begin
      r.m = x.m << sh;
      r.e = x.e - exp_t'(sh);
    end
    return r;
  endfunction

  function automatic xval_t norm_hi(input xval_t x);
    return norm_step(norm_step(norm_step(x, 32), 16), 8);
  endfunction

  function automatic xval_t norm_lo(input xval_t x);
    return norm_step(norm_step(norm_step(x, 4), 2), 1);
  endfunction

  // 64x64 mantissa product: partial products
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.p0 = a[31:0]  * b[31:0];
    r.p1 = a[31:0]  * b[63:32];
    r.p2 = a[63:32] * b[31:0];
    r.p3 = a[63:32] * b[63:32];
    return r;
  endfunction

  function automatic pm_t mul_mid(input pp_t x);
    pm_t r;
    r.p0  = x.p0;
    r.p3  = x.p3;
    r.mid = {1'b0, x.p1} + {1'b0, x.p2};
    return r;
  endfunction

  // Final carry add, keep the top 64 bits truncated
  function automatic xval_t mul_fin(input pm_t x, input exp_t esum);
    xval_t        r;
    logic [127:0] full;
    full = {x.p3, x.p0} + {31'b0, x.mid, 32'b0};
    if (full[127]) begin
      r.m = full[127:64];
      r.e = esum + exp_t'(64);
    end else begin
      r.m = full[126:63];
      r.e = esum + exp_t'(63);
    end
    return r;
  endfunction

  // a - b: order the operands and get the alignment distance
  function automatic sel_t sub_sel(input xval_t a, input xval_t b);
    sel_t r;
    logic a_big;
    r.eq  = (a.e == b.e) && (a.m == b.m);
    a_big = (a.e > b.e) || ((a.e == b.e) && (a.m > b.m));
    r.big_m   = a_big ? a.m : b.m;
    r.big_e   = a_big ? a.e : b.e;
    r.small_m = a_big ? b.m : a.m;
    r.d       = a_big ? (a.e - b.e) : (b.e - a.e);
    r.neg     = !a_big && !r.eq;
    return r;
  endfunction

  function automatic xval_t sub_fin(input sel_t s);
    xval_t       r;
    logic [63:0] sm;
    sm  = (s.d > exp_t'(63)) ? 64'd0 : (s.small_m >> s.d[5:0]);
    r.m = s.eq ? 64'd0 : (s.big_m - sm);
    r.e = s.big_e;
    return r;
  endfunction

  // Scale p * 2^k down to one bit above the output LSB
  function automatic shf_t shift_field(input fld_t f);
    shf_t r;
    logic zero;
    logic tiny;
    exp_t amt;
    zero   = (f.p == 100'd0);
    tiny   = (f.k < -exp_t'(101));
    amt    = -f.k - exp_t'(1);
    r.ksat = !zero && !f.k[EXP_W-1];
    r.neg  = f.neg;
    r.t    = (zero || r.ksat || tiny) ? 100'd0 : (f.p >> amt[6:0]);
    return r;
  endfunction

  // Round half away from zero, clip, apply sign; returns {sat, value}
  function automatic logic [48:0] round_field(input shf_t s);
    logic [63:0] r;
    logic [63:0] limit;
    logic        sat;
    logic [47:0] v;
    r     = {1'b0, s.t[63:1]} + 64'(s.t[0]);
    limit = s.neg ? 64'(NEG_MAX) : 64'(POS_MAX);
    sat   = s.ksat || (|s.t[99:64]) || (r > limit);
    if (sat) begin
      v = s.neg ? NEG_MAX : POS_MAX;
    end else begin
      v = s.neg ? 48'(-r[47:0]) : r[47:0];
    end
    return {sat, v};
  endfunction

endpackage

// ----- rtl/lennard_jones_pair_force.sv -----
// Lennard-Jones 12-6 pair force and potential, fully pipelined.
// Slave channel: one transaction carries a displacement dx, dy, dz (Q8.24).
// Master channel: one transaction carries force x/y/z and potential (Q32.16)
// plus a saturation flag, one result per input, in input order.
// Depth: 86 register stages. Throughput: one pair per cycle while the output
// is not held (see Stall below).
// The 64-step restoring divider for 1/|r|^2 (one quotient bit per stage)
// sets the depth; q-power products use 32x32 partials over three stages.
// The block keeps no state between pairs.
// Reset clears the valid bits of all stages; no transaction is in flight.
// Stall: when the output holds a result that is not taken, the whole
// pipeline freezes and s_axis_tready_o drops; nothing is lost or repeated.
// Bubbles travel as invalid stages and do not block accepted data.
module lennard_jones_pair_force
  import lj_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] dx, [63:32] dy, [95:64] dz
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [47:0] force_x, [95:48] force_y, [143:96] force_z, [191:144] potential,
  // [192] saturated, [199:193] zero
  output logic [199:0] m_axis_tdata_o
);

  localparam int unsigned SIDE_LEN = 19;
  localparam int unsigned SIDE_X4  = 14;
  localparam int unsigned SIDE_F4  = 18;

  logic                en;
  logic [N_STAGES-1:0] vld_q;

  logic [2:0][31:0] in_mag;
  logic [2:0]       in_neg;
  side_t            s1_side_q;
  logic [63:0]      s1_sq_q [3];
  logic [63:0]      s_sum;
  side_t            s2_side;

  div_t  div_q  [DIV_STEPS+1];
  side_t side_q [SIDE_LEN];

  xval_t n1_q, n2_q;
  pp_t   pp1_q, pp3_q, pp4_q, pp6_q, pp7_q;
  pm_t   pm1_q, pm3_q, pm4_q, pm6_q, pm7_q;
  exp_t  e1_q, e1b_q, e3_q, e3b_q, e4_q, e4b_q, e6_q, e6b_q, e7_q, e7b_q;
  xval_t qa_q, qb_q, qc_q, q2_q, q3_q, q4_q, q6_q, q7_q;
  xval_t q3a_q, q3b_q, q3c_q, q4a_q, q4b_q, q4c_q;

  sel_t  csel_q, psel_q;
  xval_t cx2_q, px2_q, cx3_q, px3_q, cx4_q, px4_q;
  logic  cneg2_q, pneg2_q, cneg3_q, pneg3_q, cneg4_q, pneg4_q;

  logic [63:0] fl_q [3];
  logic [63:0] fh_q [3];
  logic [95:0] fsum_q [3];
  logic [2:0]  fneg1_q, fneg2_q;
  exp_t        kf1_q, kf2_q, kp1_q, kp2_q;
  logic [63:0] pm1m_q, pm2m_q;
  logic        pneg1_q, pneg2m_q;
  fld_t        fld_q [4];
  shf_t        sh_q [4];

  logic [3:0][47:0] res_d, res_q;
  logic             sat_d, sat_q;

  // Global advance: freeze everything while the output is held
  assign en              = !vld_q[N_STAGES-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[N_STAGES-1];
  assign m_axis_tdata_o  = {7'd0, sat_q, res_q[3], res_q[2], res_q[1], res_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGES-2:0], s_axis_tvalid_i};
    end
  end

  // Input magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_neg[i] = s_axis_tdata_i[32*i+31];
      in_mag[i] = in_neg[i] ? 32'(-s_axis_tdata_i[32*i +: 32])
                            : s_axis_tdata_i[32*i +: 32];
    end
  end

  // Squared distance and close-range test
  always_comb begin
    s_sum        = s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    s2_side      = s1_side_q;
    s2_side.near = (s_sum <= NEAR_LIMIT);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      // square
      s1_side_q.mag  <= in_mag;
      s1_side_q.neg  <= in_neg;
      s1_side_q.near <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        s1_sq_q[i] <= in_mag[i] * in_mag[i];
      end

      // sum, divider setup
      div_q[0].s    <= s_sum;
      div_q[0].rem  <= NEAR_LIMIT;
      div_q[0].qr   <= '0;
      div_q[0].side <= s2_side;

      // divider, one bit per stage
      for (int j = 0; j < DIV_STEPS; j++) begin
        div_q[j+1] <= div_step(div_q[j]);
      end

      side_q[0] <= div_q[DIV_STEPS].side;
      for (int j = 1; j < SIDE_LEN; j++) begin
        side_q[j] <= side_q[j-1];
      end

      // normalize q
      n1_q <= norm_hi('{m: div_q[DIV_STEPS].qr, e: Q_EXP0});
      n2_q <= norm_lo(n1_q);

      // q2 = q*q
      pp1_q <= mul_pp(n2_q.m, n2_q.m);
      e1_q  <= n2_q.e + n2_q.e;
      qa_q  <= n2_q;
      pm1_q <= mul_mid(pp1_q);
      e1b_q <= e1_q;
      qb_q  <= qa_q;
      q2_q  <= mul_fin(pm1_q, e1b_q);
      qc_q  <= qb_q;

      // q3 = q2*q, q4 = q2*q2
      pp3_q <= mul_pp(q2_q.m, qc_q.m);
      e3_q  <= q2_q.e + qc_q.e;
      pp4_q <= mul_pp(q2_q.m, q2_q.m);
      e4_q  <= q2_q.e + q2_q.e;
      pm3_q <= mul_mid(pp3_q);
      e3b_q <= e3_q;
      pm4_q <= mul_mid(pp4_q);
      e4b_q <= e4_q;
      q3_q  <= mul_fin(pm3_q, e3b_q);
      q4_q  <= mul_fin(pm4_q, e4b_q);

      // q6 = q3*q3, q7 = q4*q3
      pp6_q <= mul_pp(q3_q.m, q3_q.m);
      e6_q  <= q3_q.e + q3_q.e;
      pp7_q <= mul_pp(q4_q.m, q3_q.m);
      e7_q  <= q4_q.e + q3_q.e;
      q3a_q <= q3_q;
      q4a_q <= q4_q;
      pm6_q <= mul_mid(pp6_q);
      e6b_q <= e6_q;
      pm7_q <= mul_mid(pp7_q);
      e7b_q <= e7_q;
      q3b_q <= q3a_q;
      q4b_q <= q4a_q;
      q6_q  <= mul_fin(pm6_q, e6b_q);
      q7_q  <= mul_fin(pm7_q, e7b_q);
      q3c_q <= q3b_q;
      q4c_q <= q4b_q;

      // coef = 2*q7 - q4, pot = q6 - q3
      csel_q  <= sub_sel('{m: q7_q.m, e: q7_q.e + exp_t'(1)}, q4c_q);
      psel_q  <= sub_sel(q6_q, q3c_q);
      cx2_q   <= sub_fin(csel_q);
      cneg2_q <= csel_q.neg;
      px2_q   <= sub_fin(psel_q);
      pneg2_q <= psel_q.neg;
      cx3_q   <= norm_hi(cx2_q);
      cneg3_q <= cneg2_q;
      px3_q   <= norm_hi(px2_q);
      pneg3_q <= pneg2_q;
      cx4_q   <= norm_lo(cx3_q);
      cneg4_q <= cneg3_q;
      px4_q   <= norm_lo(px3_q);
      pneg4_q <= pneg3_q;

      // force products coef * |d|, in 32-bit halves
      for (int i = 0; i < 3; i++) begin
        fl_q[i]    <= cx4_q.m[31:0]  * side_q[SIDE_X4].mag[i];
        fh_q[i]    <= cx4_q.m[63:32] * side_q[SIDE_X4].mag[i];
        fneg1_q[i] <= cneg4_q ^ side_q[SIDE_X4].neg[i];
      end
      kf1_q   <= cx4_q.e - exp_t'(8);
      kp1_q   <= px4_q.e + exp_t'(16);
      pm1m_q  <= px4_q.m;
      pneg1_q <= pneg4_q;

      for (int i = 0; i < 3; i++) begin
        fsum_q[i] <= {32'd0, fl_q[i]} + {fh_q[i], 32'd0};
      end
      fneg2_q  <= fneg1_q;
      kf2_q    <= kf1_q;
      kp2_q    <= kp1_q;
      pm2m_q   <= pm1m_q;
      pneg2m_q <= pneg1_q;

      // scale by the force and potential constants
      for (int i = 0; i < 3; i++) begin
        fld_q[i].p   <= 100'(fsum_q[i]) * 100'(LJ_FORCE_K);
        fld_q[i].k   <= kf2_q;
        fld_q[i].neg <= fneg2_q[i];
      end
      fld_q[3].p   <= 100'(pm2m_q) * 100'(LJ_POT_K);
      fld_q[3].k   <= kp2_q;
      fld_q[3].neg <= pneg2m_q;

      for (int i = 0; i < 4; i++) begin
        sh_q[i] <= shift_field(fld_q[i]);
      end

      // output register
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  // Rounding, clipping and close-range override
  always_comb begin
    logic [48:0] rf;
    sat_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rf       = round_field(sh_q[i]);
      res_d[i] = rf[47:0];
      sat_d    = sat_d | rf[48];
    end
    if (side_q[SIDE_F4].near) begin
      for (int i = 0; i < 3; i++) begin
        if (side_q[SIDE_F4].mag[i] == 32'd0) begin
          res_d[i] = 48'd0;
        end else begin
          res_d[i] = side_q[SIDE_F4].neg[i] ? NEG_MAX : POS_MAX;
        end
      end
      res_d[3] = POS_MAX;
      sat_d    = 1'b1;
    end
  end

endmodule

// ----- verif/lennard_jones_pair_force_tb.sv -----
`timescale 1ns / 1ps

module lennard_jones_pair_force_tb
  import lj_pkg::*;
();

  localparam int unsigned LATENCY = 86;

  typedef struct {
    logic [47:0] fx;
    logic [47:0] fy;
    logic [47:0] fz;
    logic [47:0] pot;
    logic        sat;
  } lj_result_t;

  // Floating value kept as a normalized 64-bit mantissa and an exponent
  typedef struct {
    logic [63:0] m;
    int          e;
  } xnum_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [199:0] m_axis_tdata_o;

  lj_result_t  expected_forces[$];
  int          n_errors;
  int          n_sent;
  int          n_received;
  int          n_saturated;
  bit          hold_off;
  bit          src_no_idle;
  bit          sink_no_idle;

  lennard_jones_pair_force dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Normalized product, top 64 bits truncated
  function automatic xnum_t xn_mul(xnum_t a, xnum_t b);
    xnum_t        r;
    logic [127:0] p;
    r.m = '0;
    r.e = 0;
    if (a.m == 0 || b.m == 0) return r;
    p = {64'd0, a.m} * {64'd0, b.m};
    if (p[127]) begin
      r.m = p[127:64];
      r.e = a.e + b.e + 64;
    end else begin
      r.m = p[126:63];
      r.e = a.e + b.e + 63;
    end
    return r;
  endfunction

  function automatic xnum_t xn_norm(logic [63:0] m, int e);
    xnum_t r;
    r.m = m;
    r.e = e;
    if (m == 0) begin
      r.e = 0;
      return r;
    end
    while (!r.m[63]) begin
      r.m = r.m << 1;
      r.e--;
    end
    return r;
  endfunction

  // a - b on magnitudes, sign returned apart
  function automatic xnum_t xn_sub(xnum_t a, xnum_t b, output bit neg);
    xnum_t       big;
    xnum_t       sml;
    xnum_t       z;
    logic [63:0] sm;
    int          d;
    z.m = '0;
    z.e = 0;
    neg = 0;
    if (b.m == 0) return a;
    if (a.m == 0) begin
      neg = 1;
      return b;
    end
    if (a.e == b.e && a.m == b.m) return z;
    if (a.e > b.e || (a.e == b.e && a.m > b.m)) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
      neg = 1;
    end
    d = big.e - sml.e;
    sm = (d >= 64) ? 64'd0 : (sml.m >> d);
    return xn_norm(big.m - sm, big.e);
  endfunction

  // Round m*mult*2^k to nearest (ties away), clip to 48 bits signed
  function automatic logic [47:0] round_q32_16(logic [63:0] m, logic [63:0] mult, int k,
                                              bit neg, inout bit sat);
    logic [127:0] p;
    logic [127:0] r;
    logic [127:0] limit;
    int           s;
    p = {64'd0, m} * {64'd0, mult};
    if (p == 0) return '0;
    if (k >= 0) begin
      sat = 1;
      return neg ? NEG_MAX : POS_MAX;
    end
    s = -k;
    if (s >= 102) return '0;
    p = p >> (s - 1);
    r = (p >> 1) + p[0];
    limit = neg ? 128'(NEG_MAX) : 128'(POS_MAX);
    if (r > limit) begin
      sat = 1;
      return neg ? NEG_MAX : POS_MAX;
    end
    return neg ? 48'(-r[47:0]) : r[47:0];
  endfunction

  function automatic lj_result_t predict_pair_force(logic [95:0] d);
    lj_result_t   res;
    logic [31:0]  mag[3];
    bit           negd[3];
    logic [63:0]  s;
    logic [127:0] qfull;
    logic [47:0]  f[3];
    xnum_t        q, q2, q3, q4, q6, q7, coef, pot;
    bit           cneg, pneg, sat;
    s = 0;
    sat = 0;
    for (int i = 0; i < 3; i++) begin
      negd[i] = d[32*i+31];
      mag[i]  = negd[i] ? -d[32*i +: 32] : d[32*i +: 32];
      s += {32'd0, mag[i]} * {32'd0, mag[i]};
    end
    if (s <= NEAR_LIMIT) begin
      for (int i = 0; i < 3; i++)
        f[i] = (mag[i] == 0) ? 48'd0 : (negd[i] ? NEG_MAX : POS_MAX);
      res.fx = f[0];
      res.fy = f[1];
      res.fz = f[2];
      res.pot = POS_MAX;
      res.sat = 1;
      return res;
    end
    qfull = (128'd1 << 104) / {64'd0, s};
    q  = xn_norm(qfull[63:0], -56);
    q2 = xn_mul(q, q);
    q3 = xn_mul(q2, q);
    q4 = xn_mul(q2, q2);
    q6 = xn_mul(q3, q3);
    q7 = xn_mul(q4, q3);
    if (q7.m != 0) q7.e += 1;
    coef = xn_sub(q7, q4, cneg);
    pot  = xn_sub(q6, q3, pneg);
    for (int i = 0; i < 3; i++)
      f[i] = round_q32_16(coef.m, {32'd0, mag[i]} * 64'd24, coef.e - 8, cneg != negd[i], sat);
    res.pot = round_q32_16(pot.m, 64'd4, pot.e + 16, pneg, sat);
    res.fx = f[0];
    res.fy = f[1];
    res.fz = f[2];
    res.sat = sat;
    return res;
  endfunction

  // Offer one pair and wait for the transaction
  task automatic send_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    while (!src_no_idle && $urandom_range(99) < 17) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {dz, dy, dx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_forces.push_back(predict_pair_force({dz, dy, dx}));
    n_sent++;
  endtask

  // Random Q8.24 value with a magnitude class mix
  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom();
      1: return $urandom_range(32'h40, 0) - 32'h20;
      2: return $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
      default: return $urandom_range(32'h0600_0000, 0) - 32'h0300_0000;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0100_0000;
    send_pair(0, 0, 0);
    send_pair(one, 0, 0);
    send_pair(-one, 0, 0);
    send_pair(0, one, 0);
    send_pair(0, 0, -one);
    send_pair(32'h011F_5A0B, 0, 0);             // near the force zero crossing
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_pair(32'h0010_0000, 0, 0);             // exactly at close range
    send_pair(32'h0010_0001, 0, 0);             // just outside close range
    send_pair(32'h000F_FFFF, 32'hFFF0_0001, 0);
    send_pair(32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_pair(32'h0020_0000, 32'h0020_0000, 32'h0020_0000);
    send_pair(32'h0030_0000, 32'hFFD0_0000, 0);
    send_pair(32'h00C0_0000, 32'hFF40_0000, 32'h00C0_0000);
    send_pair(32'h0400_0000, 32'hFC00_0000, 0); // far, weak attractive force
    send_pair(32'h0200_0000, 0, 0);
    send_pair(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      src_no_idle = (i >= n / 2 && i < n / 2 + 150);
      send_pair(rand_coord(), rand_coord(), rand_coord());
    end
    src_no_idle = 0;
  endtask

  // Receiver stalls long enough for the pipeline to fill
  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 200; i++)
      send_pair(rand_coord(), rand_coord(), rand_coord());
    hold_off = 0;
  endtask

  // Receiver side: ready with random idling and a long hold-off
  initial begin
    int unsigned cnt;
    bit          held;
    held = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off && !held) begin
        m_axis_tready_i <= 1'b0;
        for (cnt = 0; cnt < 300; cnt++) @(posedge clk_i);
        held = 1;
      end else begin
        if (!hold_off) held = 0;
        m_axis_tready_i <= sink_no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    lj_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_received++;
      if (expected_forces.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        exp_r = expected_forces.pop_front();
        if (exp_r.sat) n_saturated++;
        if (m_axis_tdata_o[47:0] !== exp_r.fx) begin
          $error("force_x expected %h got %h", exp_r.fx, m_axis_tdata_o[47:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[95:48] !== exp_r.fy) begin
          $error("force_y expected %h got %h", exp_r.fy, m_axis_tdata_o[95:48]);
          n_errors++;
        end
        if (m_axis_tdata_o[143:96] !== exp_r.fz) begin
          $error("force_z expected %h got %h", exp_r.fz, m_axis_tdata_o[143:96]);
          n_errors++;
        end
        if (m_axis_tdata_o[191:144] !== exp_r.pot) begin
          $error("potential expected %h got %h", exp_r.pot, m_axis_tdata_o[191:144]);
          n_errors++;
        end
        if (m_axis_tdata_o[192] !== exp_r.sat) begin
          $error("saturated expected %b got %b", exp_r.sat, m_axis_tdata_o[192]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_received = 0;
    n_saturated = 0;
    hold_off = 0;
    src_no_idle = 0;
    sink_no_idle = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    sink_no_idle = 1;
    test_random(200);
    sink_no_idle = 0;
    test_random(300);
    s_axis_tvalid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d displacement pairs, checked %0d results (%0d saturated),",
             n_sent, n_received, n_saturated);
    $display("including close range, far range, extremes and a long output stall.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
